// ----- rtl/mpba_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package mpba_pkg;

	localparam int CNT_W     = 7;
	localparam int IDX_W     = 6;
	localparam int POOL_ID_W = 3;
	localparam int CFG_W     = 56;
	localparam int TOT_W     = 32;

	localparam logic [CFG_W-1:0] CFG_RESET = 56'd6847762175886854;

	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_FREE  = 1'b1;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NO_BLOCK = 2'd1,
		ST_BAD_FREE = 2'd2
	} status_t;

	// Per-pool bookkeeping word; mark is the lowest stack level reached since
	// the last rebuild, so stack entries below it still hold their own index.
	typedef struct packed {
		logic [CNT_W-1:0] free;
		logic [CNT_W-1:0] used;
		logic [CNT_W-1:0] peak;
		logic [CNT_W-1:0] mark;
	} pool_cnt_t;

	typedef struct packed {
		logic alloc_ok;
		logic free_ok;
		logic alloc_fail;
	} stat_inc_t;

	function automatic logic [CNT_W-1:0] pool_size(
		input logic [CFG_W-1:0]     cfg,
		input logic [POOL_ID_W-1:0] pool,
		input logic [CNT_W-1:0]     max_blocks
	);
		logic [CNT_W-1:0] c;
		c = cfg[pool*CNT_W +: CNT_W];
		return (c > max_blocks) ? max_blocks : c;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/mpba_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface mpba_req_if;
	import mpba_pkg::*;
	logic                 valid;
	logic                 ready;
	logic                 kind;
	logic [POOL_ID_W-1:0] pool_id;
	logic [IDX_W-1:0]     block_index;
	modport source(output valid, kind, pool_id, block_index, input ready);
	modport sink(input valid, kind, pool_id, block_index, output ready);
endinterface

interface mpba_rsp_if;
	import mpba_pkg::*;
	logic             valid;
	logic             ready;
	status_t          status;
	logic [IDX_W-1:0] granted_block;
	logic [CNT_W-1:0] free_count;
	logic [CNT_W-1:0] used_count;
	logic [CNT_W-1:0] peak_count;
	logic [TOT_W-1:0] alloc_total;
	logic [TOT_W-1:0] free_total;
	logic [TOT_W-1:0] failure_total;
	modport source(output valid, status, granted_block, free_count, used_count, peak_count,
		alloc_total, free_total, failure_total, input ready);
	modport sink(input valid, status, granted_block, free_count, used_count, peak_count,
		alloc_total, free_total, failure_total, output ready);
endinterface

interface mpba_cfg_if;
	import mpba_pkg::*;
	logic             valid;
	logic             ready;
	logic [CFG_W-1:0] data;
	modport source(output valid, data, input ready);
	modport sink(input valid, data, output ready);
endinterface

`default_nettype wire

// ----- rtl/mpba_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mpba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		// hold read data until the next read
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ----- rtl/mpba_stats.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mpba_stats #(
	parameter int STAT_WIDTH = 32
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire mpba_pkg::stat_inc_t   inc,
	output logic      [STAT_WIDTH-1:0] alloc_nxt,
	output logic      [STAT_WIDTH-1:0] free_nxt,
	output logic      [STAT_WIDTH-1:0] fail_nxt
);
	import mpba_pkg::*;

	logic [STAT_WIDTH-1:0] alloc_q;
	logic [STAT_WIDTH-1:0] free_q;
	logic [STAT_WIDTH-1:0] fail_q;

	assign alloc_nxt = alloc_q + STAT_WIDTH'(inc.alloc_ok);
	assign free_nxt  = free_q + STAT_WIDTH'(inc.free_ok);
	assign fail_nxt  = fail_q + STAT_WIDTH'(inc.alloc_fail);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alloc_q <= '0;
			free_q  <= '0;
			fail_q  <= '0;
		end else begin
			alloc_q <= alloc_nxt;
			free_q  <= free_nxt;
			fail_q  <= fail_nxt;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/multi_pool_block_allocator_top.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Sequence: a free or a failed allocate is registered as the result from S_RD,
// a successful allocate from S_WR (pool word read, then free-list read); both wait while
// the result register is blocked. A new request is taken only in S_IDLE, after the last
// one has finished; both memory reads are serialized through the one sequencer.
// Reset: counters clear at once and every pool rebuilds from the reset block counts;
// a size register write rebuilds all pools by clearing their valid bits alone.
module multi_pool_block_allocator_top #(
	parameter int NUM_POOLS  = 8,
	parameter int MAX_BLOCKS = 64,
	parameter int STAT_WIDTH = 32
) (
	input wire logic clk,
	input wire logic arst_n,
	mpba_req_if.sink   req,
	mpba_rsp_if.source rsp,
	mpba_cfg_if.sink   cfg
);
	import mpba_pkg::*;

	localparam int PW     = (NUM_POOLS > 1) ? $clog2(NUM_POOLS) : 1;
	localparam int BW     = $clog2(MAX_BLOCKS);
	localparam int CDEPTH = 1 << PW;
	localparam int SDEPTH = 1 << (PW + BW);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_RD   = 3'b010,
		S_WR   = 3'b100
	} state_t;

	state_t               state_q;
	logic [CFG_W-1:0]     cfg_q;
	logic [CDEPTH-1:0]    pool_vld_q;
	logic                 kind_q;
	logic [POOL_ID_W-1:0] pool_q;
	logic [IDX_W-1:0]     idx_q;
	logic                 pool_ok_q;

	logic                 rsp_vld_q;
	status_t              rsp_status_q;
	logic [IDX_W-1:0]     rsp_granted_q;
	logic [CNT_W-1:0]     rsp_free_q;
	logic [CNT_W-1:0]     rsp_used_q;
	logic [CNT_W-1:0]     rsp_peak_q;
	logic [TOT_W-1:0]     rsp_alloc_tot_q;
	logic [TOT_W-1:0]     rsp_free_tot_q;
	logic [TOT_W-1:0]     rsp_fail_tot_q;

	logic                 accept;
	logic                 cfg_wr;
	logic                 out_free;
	logic [PW-1:0]        pool_a;
	logic [CNT_W-1:0]     size;
	pool_cnt_t            cnt_rd;
	pool_cnt_t            cnt;
	pool_cnt_t            cnt_new;
	logic [CNT_W-1:0]     top;
	logic [CNT_W-1:0]     used_inc;
	logic                 alloc_ok;
	logic                 free_ok;
	logic                 finish;
	logic                 cnt_wr_en;
	logic                 stk_rd_en;
	logic                 stk_wr_en;
	logic [IDX_W-1:0]     stk_rd_data;
	logic [IDX_W-1:0]     granted;
	status_t              status;
	stat_inc_t            inc;
	logic [STAT_WIDTH-1:0] alloc_nxt;
	logic [STAT_WIDTH-1:0] free_nxt;
	logic [STAT_WIDTH-1:0] fail_nxt;

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign cfg.ready = 1'b1;
	assign cfg_wr    = cfg.valid && cfg.ready;
	assign out_free  = !rsp_vld_q || rsp.ready;

	assign pool_a = pool_q[PW-1:0];
	assign size   = pool_ok_q ? pool_size(cfg_q, pool_q, CNT_W'(MAX_BLOCKS)) : '0;

	// A pool not written since the last rebuild reads as freshly built
	always_comb begin
		if (pool_vld_q[pool_a]) begin
			cnt = cnt_rd;
		end else begin
			cnt = '{free: size, used: '0, peak: '0, mark: size};
		end
	end

	assign top      = cnt.free - CNT_W'(1);
	assign used_inc = cnt.used + CNT_W'(1);
	assign alloc_ok = pool_ok_q && (size != '0) && (cnt.free != '0);
	assign free_ok  = pool_ok_q && (CNT_W'(idx_q) < size) && (cnt.free < size);

	// Entries below the mark were never pushed, so they still hold their own index
	assign granted = (top < cnt.mark) ? top[IDX_W-1:0] : stk_rd_data;

	always_comb begin
		finish    = 1'b0;
		stk_rd_en = 1'b0;
		stk_wr_en = 1'b0;
		cnt_wr_en = 1'b0;
		status    = ST_OK;
		cnt_new   = cnt;
		inc       = '0;
		unique case (state_q)
			S_IDLE: begin
			end
			S_RD: begin
				if (kind_q == KIND_ALLOC) begin
					stk_rd_en = alloc_ok;
					if (!alloc_ok) begin
						finish         = out_free;
						status         = ST_NO_BLOCK;
						inc.alloc_fail = out_free;
					end
				end else begin
					finish = out_free;
					if (free_ok) begin
						stk_wr_en    = out_free;
						cnt_wr_en    = out_free;
						inc.free_ok  = out_free;
						cnt_new.free = cnt.free + CNT_W'(1);
						cnt_new.used = cnt.used - CNT_W'(1);
					end else begin
						status = ST_BAD_FREE;
					end
				end
			end
			S_WR: begin
				finish       = out_free;
				cnt_wr_en    = out_free;
				inc.alloc_ok = out_free;
				cnt_new.free = top;
				cnt_new.used = used_inc;
				cnt_new.peak = (used_inc > cnt.peak) ? used_inc : cnt.peak;
				cnt_new.mark = (top < cnt.mark) ? top : cnt.mark;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_RD;
					end
				end
				S_RD: begin
					if (stk_rd_en) begin
						state_q <= S_WR;
					end else if (finish) begin
						state_q <= S_IDLE;
					end
				end
				S_WR: begin
					if (finish) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q    <= req.kind;
			pool_q    <= req.pool_id;
			idx_q     <= req.block_index;
			pool_ok_q <= (int'(req.pool_id) < NUM_POOLS);
		end
	end

	// A size write drops every pool word back to its rebuilt value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q      <= CFG_RESET;
			pool_vld_q <= '0;
		end else if (cfg_wr) begin
			cfg_q      <= cfg.data;
			pool_vld_q <= '0;
		end else if (cnt_wr_en) begin
			pool_vld_q[pool_a] <= 1'b1;
		end
	end

	mpba_ram #(
		.WIDTH($bits(pool_cnt_t)),
		.DEPTH(CDEPTH)
	) u_cnt_ram (
		.clk    (clk),
		.wr_en  (cnt_wr_en),
		.wr_addr(pool_a),
		.wr_data(cnt_new),
		.rd_en  (accept),
		.rd_addr(req.pool_id[PW-1:0]),
		.rd_data(cnt_rd)
	);

	mpba_ram #(
		.WIDTH(IDX_W),
		.DEPTH(SDEPTH)
	) u_stack_ram (
		.clk    (clk),
		.wr_en  (stk_wr_en),
		.wr_addr({pool_a, cnt.free[BW-1:0]}),
		.wr_data(idx_q),
		.rd_en  (stk_rd_en),
		.rd_addr({pool_a, top[BW-1:0]}),
		.rd_data(stk_rd_data)
	);

	mpba_stats #(
		.STAT_WIDTH(STAT_WIDTH)
	) u_stats (
		.clk      (clk),
		.arst_n   (arst_n),
		.inc      (inc),
		.alloc_nxt(alloc_nxt),
		.free_nxt (free_nxt),
		.fail_nxt (fail_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_vld_q <= 1'b0;
		end else if (finish) begin
			rsp_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			rsp_status_q    <= status;
			rsp_granted_q   <= (state_q == S_WR) ? granted : '0;
			rsp_free_q      <= pool_ok_q ? cnt_new.free : '0;
			rsp_used_q      <= pool_ok_q ? cnt_new.used : '0;
			rsp_peak_q      <= pool_ok_q ? cnt_new.peak : '0;
			rsp_alloc_tot_q <= TOT_W'(alloc_nxt);
			rsp_free_tot_q  <= TOT_W'(free_nxt);
			rsp_fail_tot_q  <= TOT_W'(fail_nxt);
		end
	end

	assign rsp.valid         = rsp_vld_q;
	assign rsp.status        = rsp_status_q;
	assign rsp.granted_block = rsp_granted_q;
	assign rsp.free_count    = rsp_free_q;
	assign rsp.used_count    = rsp_used_q;
	assign rsp.peak_count    = rsp_peak_q;
	assign rsp.alloc_total   = rsp_alloc_tot_q;
	assign rsp.free_total    = rsp_free_tot_q;
	assign rsp.failure_total = rsp_fail_tot_q;

	// S_WR holds while the result register is blocked
	a_wr_after_rd: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_WR |-> ($past(state_q) == S_RD || $past(state_q) == S_WR))
		else $error("free-list read stage entered without pool word read");

	a_rsp_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_vld_q) |-> $past(state_q) != S_IDLE)
		else $error("response raised with no request in flight");

	a_cfg_clears_pools: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr |=> pool_vld_q == '0)
		else $error("pool words not rebuilt after size write");

	a_one_stat_bump: assert property (@(posedge clk) disable iff (!arst_n)
		inc != '0 |-> ($countones(inc) == 1 && finish))
		else $error("statistics bumped outside a finishing request");

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps

import mpba_pkg::*;

typedef struct packed {
	status_t          status;
	logic [IDX_W-1:0] granted;
	logic [CNT_W-1:0] free_n;
	logic [CNT_W-1:0] used_n;
	logic [CNT_W-1:0] peak_n;
	logic [TOT_W-1:0] allocs;
	logic [TOT_W-1:0] frees;
	logic [TOT_W-1:0] fails;
} reply_t;

class pool_scoreboard;
	logic [CFG_W-1:0] sizes_reg;
	logic [IDX_W-1:0] stack [8][64];
	logic [CNT_W-1:0] n_free [8];
	logic [CNT_W-1:0] n_used [8];
	logic [CNT_W-1:0] n_peak [8];
	logic [TOT_W-1:0] allocs;
	logic [TOT_W-1:0] frees;
	logic [TOT_W-1:0] fails;
	logic [63:0]      out_mask [8];
	reply_t           replies_due [$];
	int               errors;

	function new();
		allocs = '0;
		frees = '0;
		fails = '0;
		errors = 0;
	endfunction

	function logic [CNT_W-1:0] size_of(int p);
		logic [CNT_W-1:0] c;
		c = sizes_reg[p*CNT_W +: CNT_W];
		return (c > 7'd64) ? 7'd64 : c;
	endfunction

	// Rebuild every pool; the global totals carry over.
	function void rebuild(logic [CFG_W-1:0] v);
		sizes_reg = v;
		for (int p = 0; p < 8; p++) begin
			for (int j = 0; j < 64; j++)
				stack[p][j] = IDX_W'(j);
			n_free[p] = size_of(p);
			n_used[p] = '0;
			n_peak[p] = '0;
			out_mask[p] = '0;
		end
	endfunction

	function void note_request(logic k, logic [POOL_ID_W-1:0] p, logic [IDX_W-1:0] b);
		reply_t r;
		logic [CNT_W-1:0] sz;
		sz = size_of(p);
		r.granted = '0;
		if (k == KIND_ALLOC) begin
			if (sz != 0 && n_free[p] != 0) begin
				n_free[p] = n_free[p] - 7'd1;
				r.granted = stack[p][n_free[p][5:0]];
				n_used[p] = n_used[p] + 7'd1;
				if (n_used[p] > n_peak[p])
					n_peak[p] = n_used[p];
				allocs = allocs + 1;
				out_mask[p][r.granted] = 1'b1;
				r.status = ST_OK;
			end else begin
				fails = fails + 1;
				r.status = ST_NO_BLOCK;
			end
		end else begin
			// No guard check: a repeated free goes through while the pool has room.
			if (b < sz && n_free[p] < sz) begin
				stack[p][n_free[p][5:0]] = b;
				n_free[p] = n_free[p] + 7'd1;
				n_used[p] = n_used[p] - 7'd1;
				frees = frees + 1;
				out_mask[p][b] = 1'b0;
				r.status = ST_OK;
			end else begin
				r.status = ST_BAD_FREE;
			end
		end
		r.free_n = n_free[p];
		r.used_n = n_used[p];
		r.peak_n = n_peak[p];
		r.allocs = allocs;
		r.frees = frees;
		r.fails = fails;
		replies_due.push_back(r);
	endfunction

	function int pick_held(int p);
		int cands [$];
		for (int i = 0; i < 64; i++)
			if (out_mask[p][i])
				cands.push_back(i);
		if (cands.size() == 0)
			return -1;
		return cands[$urandom_range(0, cands.size() - 1)];
	endfunction

	function void same_field(string name, logic [TOT_W-1:0] want_v, logic [TOT_W-1:0] got_v);
		if (want_v !== got_v) begin
			errors++;
			if (errors <= 40)
				$display("%0t: %s expected %0d actual %0d", $time, name, want_v, got_v);
		end
	endfunction

	function void check_reply(reply_t got);
		reply_t want;
		if (replies_due.size() == 0) begin
			errors++;
			if (errors <= 40)
				$display("%0t: reply with none pending, expected none actual status %0d",
					$time, got.status);
			return;
		end
		want = replies_due.pop_front();
		same_field("status", want.status, got.status);
		same_field("granted_block", want.granted, got.granted);
		same_field("free_count", want.free_n, got.free_n);
		same_field("used_count", want.used_n, got.used_n);
		same_field("peak_count", want.peak_n, got.peak_n);
		same_field("alloc_total", want.allocs, got.allocs);
		same_field("free_total", want.frees, got.frees);
		same_field("failure_total", want.fails, got.fails);
	endfunction
endclass

module tb_top;
	logic clk;
	logic arst_n;

	mpba_req_if req();
	mpba_rsp_if rsp();
	mpba_cfg_if cfg();

	multi_pool_block_allocator_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp),
		.cfg(cfg)
	);

	pool_scoreboard sb;
	reply_t         seen;
	int             stall_mode = 0;
	int             stall_left = 0;
	logic [7:0]     stall_pattern = 8'hff;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("simulation failed");
		$finish;
	end

	// Result side: check each beat, then pick the next ready value.
	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready) begin
			seen = '{rsp.status, rsp.granted_block, rsp.free_count, rsp.used_count,
				rsp.peak_count, rsp.alloc_total, rsp.free_total, rsp.failure_total};
			sb.check_reply(seen);
		end
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 2);
			stall_left = $urandom_range(40, 300);
			stall_pattern = 8'($urandom) | 8'h01;
		end else begin
			stall_left--;
		end
		case (stall_mode)
			0: rsp.ready <= 1'b1;
			1: rsp.ready <= ($urandom_range(0, 3) != 0);
			default: begin
				rsp.ready <= stall_pattern[0];
				stall_pattern = {stall_pattern[0], stall_pattern[7:1]};
			end
		endcase
	end

	task automatic send_request(input logic k, input logic [POOL_ID_W-1:0] p,
		input logic [IDX_W-1:0] b);
		req.valid <= 1'b1;
		req.kind <= k;
		req.pool_id <= p;
		req.block_index <= b;
		do @(posedge clk); while (!req.ready);
		sb.note_request(k, p, b);
	endtask

	task automatic drain();
		req.valid <= 1'b0;
		while (sb.replies_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_sizes(input logic [CFG_W-1:0] v);
		drain();
		repeat (4) @(posedge clk);
		cfg.valid <= 1'b1;
		cfg.data <= v;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		sb.rebuild(v);
	endtask

	function automatic logic [CFG_W-1:0] pack_sizes(input int lo, input int hi);
		logic [CFG_W-1:0] v;
		for (int p = 0; p < 8; p++)
			v[p*CNT_W +: CNT_W] = CNT_W'($urandom_range(lo, hi));
		return v;
	endfunction

	initial begin
		int burst_left;
		int gap;
		int held;
		int n;
		bit steady;
		logic k;
		logic [POOL_ID_W-1:0] p;
		logic [IDX_W-1:0] b;

		req.valid = 1'b0;
		req.kind = KIND_ALLOC;
		req.pool_id = '0;
		req.block_index = '0;
		rsp.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.data = '0;
		arst_n = 1'b0;
		sb = new();
		sb.rebuild(CFG_RESET);
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset sizes: one allocate per pool, then frees against them.
		for (int i = 0; i < 8; i++)
			send_request(KIND_ALLOC, POOL_ID_W'(i), '0);
		send_request(KIND_FREE, 3'd0, 6'd0);
		send_request(KIND_FREE, 3'd0, 6'd0);
		send_request(KIND_FREE, 3'd3, 6'd63);

		// Pool 0 of two, pool 1 off, pools 2 and 5 above the cap.
		write_sizes({7'd63, 7'd3, 7'd65, 7'd1, 7'd64, 7'd127, 7'd0, 7'd2});
		send_request(KIND_ALLOC, 3'd0, 6'd63);
		send_request(KIND_ALLOC, 3'd0, 6'd0);
		send_request(KIND_ALLOC, 3'd0, 6'd0);
		send_request(KIND_FREE, 3'd0, 6'd1);
		send_request(KIND_FREE, 3'd0, 6'd1);
		send_request(KIND_FREE, 3'd0, 6'd0);
		send_request(KIND_FREE, 3'd0, 6'd2);
		send_request(KIND_ALLOC, 3'd1, 6'd0);
		send_request(KIND_FREE, 3'd1, 6'd0);
		send_request(KIND_ALLOC, 3'd2, 6'd0);
		send_request(KIND_FREE, 3'd2, 6'd63);
		send_request(KIND_ALLOC, 3'd4, 6'd0);
		send_request(KIND_ALLOC, 3'd4, 6'd0);
		send_request(KIND_FREE, 3'd4, 6'd63);
		send_request(KIND_ALLOC, 3'd7, 6'd0);
		send_request(KIND_FREE, 3'd7, 6'd62);

		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: write_sizes('1);
				1: write_sizes(pack_sizes(0, 4));
				2: write_sizes('0);
				3: write_sizes(CFG_W'({$urandom, $urandom}));
				4: write_sizes(pack_sizes(64, 64));
				5: write_sizes(pack_sizes(1, 6));
				6: write_sizes(pack_sizes(0, 127));
				default: write_sizes(CFG_RESET);
			endcase
			steady = ($urandom_range(0, 3) == 0);
			burst_left = 0;
			n = (ph == 2) ? 60 : 260;
			for (int i = 0; i < n; i++) begin
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 24);
					gap = steady ? 0 : $urandom_range(0, 6);
					if (gap > 0) begin
						req.valid <= 1'b0;
						repeat (gap) @(posedge clk);
					end
				end
				burst_left--;
				p = $urandom_range(0, 7);
				b = $urandom_range(0, 63);
				if ($urandom_range(0, 99) < 70) begin
					// Return a block that is really out half the time, else take one.
					held = sb.pick_held(p);
					if (held >= 0 && $urandom_range(0, 1) == 1) begin
						k = KIND_FREE;
						b = IDX_W'(held);
					end else begin
						k = KIND_ALLOC;
					end
				end else begin
					k = ($urandom_range(0, 1) == 1) ? KIND_FREE : KIND_ALLOC;
				end
				send_request(k, p, b);
			end
		end

		drain();
		repeat (10) @(posedge clk);
		if (sb.errors == 0 && sb.replies_due.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
